// ===== design/rgb2hsv_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
package rgb2hsv_pkg;

    localparam int unsigned QuotBits = 8;   // quotient width of both dividers
    localparam int unsigned HueBits  = 9;

    // Hue sector selected by the largest channel
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Data carried from cell to cell
    typedef struct packed {
        logic [15:0]   sat_rem;   // partial remainder, saturation divide
        logic [7:0]    sat_quo;
        logic [7:0]    maxv;
        logic [13:0]   hue_rem;   // partial remainder, hue divide
        logic [7:0]    hue_quo;
        logic [7:0]    delta;
        logic          neg;
        t_sector       sector;
    } t_cell_data;

endpackage

// ===== design/rgb_to_hsv_convert.sv =====
// Top level of the pipelined RGB to HSV converter.
// Takes one pixel per clock and returns one HSV result per pixel: one
// front cell finds max, min and the sector, eight division cells each
// produce one quotient bit of saturation and hue, and an output
// register adds the sector base. The whole row advances when the output
// register is empty or being read, so throughput is one pixel per cycle.
module rgb_to_hsv_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hue[8:0], saturation[16:9],
                                        // brightness[24:17], hue_undefined[25]
);
    import rgb2hsv_pkg::*;

    localparam int unsigned NCells = QuotBits;

    logic [7:0]   w_r, w_g, w_b, w_max, w_min, w_p, w_q;
    t_sector      w_sec;
    logic         w_en;
    t_cell_data   n_front;
    logic         w_valid [NCells+1];
    t_cell_data   w_data  [NCells+1];
    logic         r_front_valid;
    t_cell_data   r_front;
    logic         r_out_valid;
    logic [31:0]  r_out;
    logic [31:0]  n_out;
    logic [9:0]   w_base;
    logic [9:0]   w_h;
    t_cell_data   w_last;

    assign w_r = s_axis_tdata[7:0];
    assign w_g = s_axis_tdata[15:8];
    assign w_b = s_axis_tdata[23:16];

    // Advance the row whenever the output slot frees up
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // Pick max channel (red, then green) and the hue difference operands
    always_comb begin
        w_max = w_r;
        w_min = w_r;
        if (w_g > w_max) w_max = w_g;
        if (w_b > w_max) w_max = w_b;
        if (w_g < w_min) w_min = w_g;
        if (w_b < w_min) w_min = w_b;
        priority if (w_r == w_max) begin
            w_sec = SEC_RED;   w_p = w_g; w_q = w_b;
        end else if (w_g == w_max) begin
            w_sec = SEC_GREEN; w_p = w_b; w_q = w_r;
        end else begin
            w_sec = SEC_BLUE;  w_p = w_r; w_q = w_g;
        end
        n_front.maxv    = w_max;
        n_front.delta   = w_max - w_min;
        n_front.sat_rem = 16'((w_max - w_min) * 16'd255);
        n_front.sat_quo = '0;
        n_front.neg     = w_p < w_q;
        n_front.hue_rem = (w_p >= w_q) ? 14'((w_p - w_q) * 14'd60)
                                       : 14'((w_q - w_p) * 14'd60);
        n_front.hue_quo = '0;
        n_front.sector  = w_sec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_en) begin
            r_front_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front <= n_front;
        end
    end

    assign w_valid[0] = r_front_valid;
    assign w_data[0]  = r_front;

    // Row of division cells, one quotient bit each
    for (genvar gi = 0; gi < NCells; gi++) begin : g_cell
        rgb2hsv_cell #(.STEP(gi)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .i_data  (w_data[gi]),
            .i_en    (w_en),
            .o_valid (w_valid[gi+1]),
            .o_data  (w_data[gi+1])
        );
    end

    // Add sector base, wrap negatives, pack the result
    assign w_last = w_data[NCells];
    always_comb begin
        unique case (w_last.sector)
            SEC_RED:   w_base = 10'd0;
            SEC_GREEN: w_base = 10'd120;
            SEC_BLUE:  w_base = 10'd240;
            default:   w_base = 10'd0;
        endcase
        if (w_last.neg) begin
            w_h = w_base - {2'd0, w_last.hue_quo};
            // A negative offset that truncates to zero stays at zero
            if (w_last.sector == SEC_RED && w_last.hue_quo != 8'd0) begin
                w_h = w_h + 10'd360;
            end
        end else begin
            w_h = w_base + {2'd0, w_last.hue_quo};
        end
        n_out = '0;
        if (w_last.delta == 8'd0) begin
            n_out[8:0] = '0;
            n_out[25]  = 1'b1;
        end else begin
            n_out[8:0] = w_h[HueBits-1:0];
        end
        n_out[16:9]  = (w_last.maxv == 8'd0) ? 8'd0 : w_last.sat_quo;
        n_out[24:17] = w_last.maxv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[NCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Hue stays in range
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:0] < 9'd360)
        else $error("hue out of range");

    // Undefined hue reads as zero with zero saturation
    a_undef: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[25]) |->
        (m_axis_tdata[8:0] == 9'd0 && m_axis_tdata[16:9] == 8'd0))
        else $error("undefined hue not clean");

    // Stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule

// ===== design/rgb2hsv_cell.sv =====
// One restoring-division cell: one quotient bit of each divider.
module rgb2hsv_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  rgb2hsv_pkg::t_cell_data i_data,
    input  logic                    i_en,
    output logic                    o_valid,
    output rgb2hsv_pkg::t_cell_data o_data
);
    import rgb2hsv_pkg::*;

    localparam int unsigned Shift = QuotBits - 1 - STEP;

    logic [23:0]  w_sat_div;
    logic [21:0]  w_hue_div;
    logic         w_sat_ge;
    logic         w_hue_ge;
    t_cell_data   n_data;
    t_cell_data   r_data;
    logic         r_valid;

    // Compare remainder against shifted divisor, subtract when it fits
    assign w_sat_div = {16'd0, i_data.maxv} << Shift;
    assign w_hue_div = {14'd0, i_data.delta} << Shift;
    assign w_sat_ge  = {8'd0, i_data.sat_rem} >= w_sat_div;
    assign w_hue_ge  = {8'd0, i_data.hue_rem} >= w_hue_div;

    always_comb begin
        n_data = i_data;
        if (w_sat_ge) begin
            n_data.sat_rem = i_data.sat_rem - w_sat_div[15:0];
        end
        if (w_hue_ge) begin
            n_data.hue_rem = i_data.hue_rem - w_hue_div[13:0];
        end
        n_data.sat_quo[Shift] = w_sat_ge;
        n_data.hue_quo[Shift] = w_hue_ge;
    end

    // Advance when the stage is allowed to move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
